/* rtl/wildcard_glob_matcher_top_macros.svh */
// Assertion macros for the wildcard glob matcher checker.
// Used by wgm_checker.sv; expects clk and rst in scope.
`ifndef WILDCARD_GLOB_MATCHER_TOP_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define WGM_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define WGM_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/wgm_pkg.sv */
// Shared types and constants for the wildcard glob matcher.
// No dependencies; used by the cell, the top level and the checker.
`default_nettype none

package wgm_pkg;

  localparam int SYM_W  = 8;
  localparam int MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEXT   = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;
  localparam logic [SYM_W-1:0] ANY_BYTE  = 8'h3F;

  // Handed from one cell to the next: store fill, old active bit, new closed bit.
  typedef struct packed {
    logic vld;
    logic act;
    logic closed;
  } link_t;

endpackage

`default_nettype wire

/* rtl/wgm_cell.sv */
// One pattern position of the matcher: stored byte, fill bit, active bit.
// Depends on wgm_pkg for mode codes, wildcard bytes and the link struct.
`default_nettype none

module wgm_cell
  import wgm_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              en,
  input  mode_t            mode,
  input  wire  [SYM_W-1:0] sym,
  input  link_t            lin,
  output link_t            lout,
  output logic             hit
);

  logic             vld;
  logic             act;
  logic [SYM_W-1:0] pat;

  logic             write;
  logic             vld_next;
  logic [SYM_W-1:0] pat_next;
  logic             star_next;
  logic             raw;
  logic             closed;

  // Take the byte when this is the first empty cell in the row.
  assign write = en && (mode == MODE_APPEND) && lin.vld && !vld;

  always_comb begin
    vld_next = vld;
    if (en) begin
      unique case (mode)
        MODE_CLEAR:  vld_next = 1'b0;
        MODE_APPEND: vld_next = vld | write;
        MODE_TEXT:   vld_next = vld;
        MODE_END:    vld_next = vld;
        default:     vld_next = vld;
      endcase
    end
  end

  assign pat_next  = write ? sym : pat;
  assign star_next = (pat_next == STAR_BYTE);

  always_comb begin
    raw = 1'b0;
    if (mode == MODE_TEXT && vld) begin
      if (pat == STAR_BYTE) begin
        raw = lin.act | act;
      end else begin
        raw = lin.act & ((pat == ANY_BYTE) | (pat == sym));
      end
    end
  end

  // Star closure ripples in from the previous position.
  assign closed = raw | (vld_next & star_next & lin.closed);

  assign lout.vld    = vld;
  assign lout.act    = act;
  assign lout.closed = closed;

  // Previous position is the last one of the pattern.
  assign hit = lin.vld & !vld & lin.act;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      act <= 1'b0;
    end else begin
      vld <= vld_next;
      if (en) begin
        act <= closed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      pat <= sym;
    end
  end

endmodule

`default_nettype wire

/* rtl/wildcard_glob_matcher_top.sv */
// An end-of-text word yields its result word in the cycle after acceptance.
// Throughput: one input word per cycle while the output does not stall; text bytes,
// pattern bytes and end marks alike. The active-position update and star closure
// ripple combinationally through the row of PATTERN_MAX cells; the result sits in
// one output register. Reset (rst, synchronous, active high): empty pattern, no
// overflow, position zero active, output empty. Stored pattern bytes are not cleared.
`default_nettype none

module wildcard_glob_matcher_top
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  wire  [7:0]       s_tdata,   // [7:0] symbol
  input  wire  [1:0]       s_tuser,   // [1:0] mode
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [7:0]       m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

  mode_t             mode;
  logic              accept;
  logic              act0;
  logic              act0_next;
  logic              ovf;
  logic              match;
  link_t             links [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] hits;

  assign mode     = mode_t'(s_tuser);
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Position zero is dropped by any text byte and set again on every rearm.
  assign act0_next = (mode != MODE_TEXT);

  assign links[0].vld    = 1'b1;
  assign links[0].act    = act0;
  assign links[0].closed = act0_next;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    wgm_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (accept),
      .mode (mode),
      .sym  (s_tdata),
      .lin  (links[k]),
      .lout (links[k+1]),
      .hit  (hits[k])
    );
  end

  assign match = (|hits) | (links[PATTERN_MAX].vld & links[PATTERN_MAX].act);

  always_ff @(posedge clk) begin
    if (rst) begin
      act0     <= 1'b1;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        act0 <= act0_next;
        if (mode == MODE_CLEAR) begin
          ovf <= 1'b0;
        end else if (mode == MODE_APPEND && links[PATTERN_MAX].vld) begin
          ovf <= 1'b1;
        end
      end
      if (accept && mode == MODE_END) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode == MODE_END) begin
      m_tdata <= {6'b0, ovf, !ovf & match};
    end
  end

endmodule

`default_nettype wire

/* rtl/wgm_checker.sv */
// Port-level checks for the wildcard glob matcher, bound to the top level.
// Depends on wgm_pkg and wildcard_glob_matcher_top_macros.svh.
`default_nettype none
`include "wildcard_glob_matcher_top_macros.svh"

module wgm_checker
  import wgm_pkg::*;
(
  input wire       clk,
  input wire       rst,
  input wire       s_tvalid,
  input wire       s_tready,
  input wire [7:0] s_tdata,
  input wire [1:0] s_tuser,
  input wire       m_tvalid,
  input wire       m_tready,
  input wire [7:0] m_tdata
);

  logic end_taken;

  assign end_taken = s_tvalid && s_tready && (s_tuser == MODE_END);

  // An overflowed pattern never reports a match.
  `WGM_ASSERT_CLK(a_ovf_no_match, m_tvalid |-> !(m_tdata[0] && m_tdata[1]), "match with overflow")

  // Every accepted end mark produces a result word next cycle.
  `WGM_ASSERT_CLK(a_end_result, end_taken |=> m_tvalid, "end of text gave no result")

  // Input side stays open while the output register is empty.
  `WGM_ASSERT_CLK(a_ready_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

  // A stalled result word holds.
  `WGM_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind wildcard_glob_matcher_top wgm_checker u_wgm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
